FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sc_pkg.sv
// Types and constants of the second-chance cache.
`default_nettype none

package sc_pkg;

	// Width of the capacity register
	localparam int CAP_W = 5;

	// Command transferred on start
	typedef struct packed {
		logic               op;
		logic signed [31:0] key;
		logic signed [31:0] write_value;
	} sc_cmd_t;

	// Result transferred on done
	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} sc_rsp_t;

	// One stored entry
	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] value;
	} sc_entry_t;

	// Command codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SWEEP
	} sc_state_t;

endpackage

`default_nettype wire

FILE: rtl/second_chance_cache_top.sv
// Top level of the second-chance (clock) replacement key/value cache.
//
// Command channel: cmd is transferred at a rising edge with start high and
// busy low. op lookup returns one result; op insert returns none.
// Result channel: done is high for one cycle with rsp valid; the receiver
// cannot hold it off, so results are never delayed by the output side.
// Capacity register: cfg_we writes cfg_wdata; 0 acts as 1, values above the
// slot count act as the slot count. Every write also empties the cache.
// Keys and values live in one memory read once per cycle; the key search
// streams through that read port, one entry per cycle.
// A lookup ends its search at the first hit or after entry cap-1; done is a
// register set at the end of the search, and the result is taken at the
// edge that ends the done cycle. An insert also ends at a hit and updates
// the value; else it appends, or, when the cache is full, sweeps the hand
// past k referenced entries (k at most cap), one bit per cycle, and evicts.
// busy drops in the cycle done is high, so the next command is transferred
// at the edge that takes the result.
// Reset: empty cache, capacity equal to the slot count, busy low. Valid and
// reference bits are flops cleared at once; no memory clearing pass.
`default_nettype none

module second_chance_cache_top #(
	parameter int SLOTS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire sc_pkg::sc_cmd_t            cmd,
	output logic                            busy,
	output logic                            done,
	output sc_pkg::sc_rsp_t                 rsp,
	input  wire logic                       cfg_we,
	input  wire logic [sc_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int CAPW = sc_pkg::CAP_W;
	// slots reachable by a CAPW-bit capacity
	localparam int USED = (SLOTS < (1 << CAPW)) ? SLOTS : (1 << CAPW) - 1;
	localparam int IW   = (USED > 1) ? $clog2(USED) : 1;
	localparam int CW   = $clog2(USED + 1);

	sc_pkg::sc_state_t state_q, state_d;

	logic [CAPW-1:0] cap_cfg_q;
	logic [CW-1:0]   cap_eff;
	logic [USED-1:0] valid_q;
	logic [USED-1:0] ref_q;
	logic [IW-1:0]   hand_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   scan_q;
	logic            cmp_vld_s1;
	logic [CW-1:0]   cmp_idx_s1;

	logic               op_q;
	logic signed [31:0] key_q;
	logic signed [31:0] wval_q;

	logic               done_q;
	sc_pkg::sc_rsp_t    rsp_q;

	sc_pkg::sc_entry_t  rd_entry;
	sc_pkg::sc_entry_t  wr_entry;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;

	logic            accept;
	logic            issue;
	logic            match;
	logic            last;
	logic            search_end;
	logic            full;
	logic            hand_ref;
	logic [CW:0]     pos_sum;
	logic [IW-1:0]   pos;
	logic [CW-1:0]   hand_inc;
	logic [IW-1:0]   hand_next;

	// outputs of the sequencer
	logic            rsp_fire;
	logic            set_ref;
	logic            append;
	logic            sweep_skip;
	logic            sweep_evict;

	// effective capacity
	always_comb begin
		if (cap_cfg_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_cfg_q > CAPW'(USED)) begin
			cap_eff = CW'(USED);
		end else begin
			cap_eff = CW'(cap_cfg_q);
		end
	end

	// search and ring arithmetic
	assign accept     = start && (state_q == sc_pkg::ST_IDLE);
	assign issue      = (state_q == sc_pkg::ST_SEARCH) && (scan_q < cap_eff);
	assign match      = cmp_vld_s1 && valid_q[cmp_idx_s1[IW-1:0]] && (rd_entry.key == key_q);
	assign last       = cmp_vld_s1 && (cmp_idx_s1 == CW'(cap_eff - CW'(1)));
	assign search_end = match || last;
	assign full       = (fill_q >= cap_eff);
	assign hand_ref   = ref_q[hand_q];

	always_comb begin
		pos_sum = {1'b0, CW'(hand_q)} + {1'b0, fill_q};
		if (pos_sum >= {1'b0, cap_eff}) begin
			pos_sum = pos_sum - {1'b0, cap_eff};
		end
		pos = pos_sum[IW-1:0];
	end

	always_comb begin
		hand_inc  = CW'(hand_q) + CW'(1);
		hand_next = (hand_inc == cap_eff) ? '0 : hand_inc[IW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = sc_pkg::ST_SEARCH;
				end
			end
			sc_pkg::ST_SEARCH: begin
				if (search_end) begin
					if (op_q == sc_pkg::OP_INSERT && !match && full) begin
						state_d = sc_pkg::ST_SWEEP;
					end else begin
						state_d = sc_pkg::ST_IDLE;
					end
				end
			end
			sc_pkg::ST_SWEEP: begin
				if (!hand_ref) begin
					state_d = sc_pkg::ST_IDLE;
				end
			end
			default: state_d = sc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rsp_fire    = 1'b0;
		set_ref     = 1'b0;
		append      = 1'b0;
		sweep_skip  = 1'b0;
		sweep_evict = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = cmp_idx_s1[IW-1:0];
		case (state_q)
			sc_pkg::ST_SEARCH: begin
				if (search_end) begin
					if (op_q == sc_pkg::OP_LOOKUP) begin
						rsp_fire = 1'b1;
						set_ref  = match;
					end else if (match) begin
						mem_we = 1'b1;
					end else if (!full) begin
						append    = 1'b1;
						mem_we    = 1'b1;
						mem_waddr = pos;
					end
				end
			end
			sc_pkg::ST_SWEEP: begin
				if (hand_ref) begin
					sweep_skip = 1'b1;
				end else begin
					sweep_evict = 1'b1;
					mem_we      = 1'b1;
					mem_waddr   = hand_q;
				end
			end
			default: ;
		endcase
	end

	assign wr_entry.key   = key_q;
	assign wr_entry.value = wval_q;

	sc_mem #(
		.DEPTH (USED),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wr_entry),
		.raddr (scan_q[IW-1:0]),
		.rdata (rd_entry)
	);

	// state and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sc_pkg::ST_IDLE;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue && !search_end;
			cmp_idx_s1 <= scan_q;
			if (accept) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= CW'(scan_q + CW'(1));
			end
		end
	end

	// command capture, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			key_q  <= cmd.key;
			wval_q <= cmd.write_value;
		end
	end

	// capacity, valid and reference bits, clock hand, fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q <= CAPW'(USED);
			valid_q   <= '0;
			ref_q     <= '0;
			hand_q    <= '0;
			fill_q    <= '0;
		end else if (cfg_we) begin
			cap_cfg_q <= cfg_wdata;
			valid_q   <= '0;
			ref_q     <= '0;
			hand_q    <= '0;
			fill_q    <= '0;
		end else begin
			if (set_ref) begin
				ref_q[cmp_idx_s1[IW-1:0]] <= 1'b1;
			end
			if (append) begin
				valid_q[pos] <= 1'b1;
				ref_q[pos]   <= 1'b0;
				fill_q       <= CW'(fill_q + CW'(1));
			end
			if (sweep_skip) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_next;
			end
			if (sweep_evict) begin
				valid_q[hand_q] <= 1'b1;
				hand_q          <= hand_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_fire) begin
			rsp_q.hit        <= match;
			rsp_q.read_value <= match ? rd_entry.value : '0;
		end
	end

	assign busy = (state_q != sc_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/sc_mem.sv
// Key/value memory: one write port, one read port with registered data.
`default_nettype none

module sc_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire sc_pkg::sc_entry_t wdata,
	input  wire logic [AW-1:0]     raddr,
	output sc_pkg::sc_entry_t      rdata
);

	sc_pkg::sc_entry_t mem [DEPTH];
	sc_pkg::sc_entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/sc_checker.sv
// Port-level checker of the cache handshake timing, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// a result closes its item: busy drops in the same cycle
	`SC_ASSERT_IMP(a_done_ends_item, clk, arst_n, done, !busy && $past(busy), "done without item")

	// a transfer makes the block busy in the next cycle
	`SC_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "transfer not taken")

	// no result in the cycle right after a transfer
	`SC_ASSERT_NXT(a_no_early_done, clk, arst_n, start && !busy, !done, "result too early")

	// one result per item
	`SC_ASSERT_NXT(a_single_done, clk, arst_n, done, !done, "result repeated")

endmodule

bind second_chance_cache_top sc_checker u_sc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
